>>> rtl/dlfs_pkg.sv
// Shared types and constants for the dual-length frame splitter.
package dlfs_pkg;

   // Header layout: total length word, then metadata length word
   localparam int HDR_BYTES      = 8;
   localparam int WORD_BYTES     = 4;
   localparam int HDR_BITS       = HDR_BYTES * 8;
   localparam int HDR_CNT_BITS   = 3;
   localparam int TOTAL_OVERHEAD = 4;

   // Result kind codes
   localparam logic [1:0] KIND_META  = 2'd0;
   localparam logic [1:0] KIND_FILE  = 2'd1;
   localparam logic [1:0] KIND_EMPTY = 2'd2;
   localparam logic [1:0] KIND_BAD   = 2'd3;

   // Parser phase, one-hot
   typedef enum logic [3:0] {
      PH_HEADER = 4'b0001,
      PH_META   = 4'b0010,
      PH_FILE   = 4'b0100,
      PH_SKIP   = 4'b1000
   } phase_type;

   // One result transaction
   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] kind;
      logic       last_in_part;
      logic       last_in_frame;
   } rsp_type;

endpackage

>>> rtl/dual_length_frame_splitter.sv
// A result is registered in the output buffer when the byte that causes it is accepted.
// Throughput: one byte per cycle unless req_stall is high; the parser update
// is a single register-to-register pass; a skid register absorbs one output stall.
// Reset (synchronous, active high) returns the parser to the header phase
// with all counters cleared and empties the result registers.
module dual_length_frame_splitter #(
   parameter int LEN_BITS = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic [1:0] rsp_kind,
   output logic       rsp_last_in_part,
   output logic       rsp_last_in_frame
);

   logic              accept;
   logic              res_valid;
   dlfs_pkg::rsp_type res;
   dlfs_pkg::rsp_type rsp_data;

   assign accept = req_valid && !req_stall;

   // Parse the stream
   dlfs_parser #(
      .LEN_BITS (LEN_BITS)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .in_byte   (req_in_byte),
      .res_valid (res_valid),
      .res       (res)
   );

   // Buffer results toward the output channel
   dlfs_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (accept && res_valid),
      .push_data (res),
      .full      (req_stall),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_data)
   );

   assign rsp_out_byte      = rsp_data.out_byte;
   assign rsp_kind          = rsp_data.kind;
   assign rsp_last_in_part  = rsp_data.last_in_part;
   assign rsp_last_in_frame = rsp_data.last_in_frame;

   // Input stalls only while a result is waiting in the skid stage
   a_stall_needs_output: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with no pending result");

   // Status-only results carry no byte and close the frame
   a_status_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == dlfs_pkg::KIND_EMPTY || rsp_kind == dlfs_pkg::KIND_BAD)
      |-> rsp_out_byte == 8'd0 && rsp_last_in_frame && !rsp_last_in_part)
      else $error("malformed status result");

   // The end of the file part is always the end of the frame
   a_file_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == dlfs_pkg::KIND_FILE
      |-> rsp_last_in_part == rsp_last_in_frame)
      else $error("file part end disagrees with frame end");

endmodule

>>> rtl/dlfs_parser.sv
// Header parser and body tagger: consumes one byte per accepted transaction.
module dlfs_parser #(
   parameter int LEN_BITS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        in_byte,
   output logic              res_valid,
   output dlfs_pkg::rsp_type res
);

   localparam logic [dlfs_pkg::HDR_CNT_BITS-1:0] HDR_LAST =
      dlfs_pkg::HDR_CNT_BITS'(dlfs_pkg::HDR_BYTES - 1);
   localparam logic [LEN_BITS-1:0] OVERHEAD = LEN_BITS'(dlfs_pkg::TOTAL_OVERHEAD);
   localparam logic [LEN_BITS-1:0] ONE      = LEN_BITS'(1);
   localparam int TOTAL_LSB = dlfs_pkg::WORD_BYTES * 8;

   dlfs_pkg::phase_type                phase_ff, phase_in, phase_eff;
   logic [dlfs_pkg::HDR_CNT_BITS-1:0]  hdr_cnt_ff, hdr_cnt_in;
   logic [dlfs_pkg::HDR_BITS-1:0]      hdr_shift_ff, hdr_shift_in;
   logic [LEN_BITS-1:0]                meta_rem_ff, meta_rem_in;
   logic [LEN_BITS-1:0]                body_rem_ff, body_rem_in;

   logic [dlfs_pkg::HDR_BITS-1:0]      hdr_full;
   logic [LEN_BITS-1:0]                total_word, meta_len, body_len;

   // Resolve phases whose counter is already exhausted
   always_comb begin
      phase_eff = phase_ff;
      if (phase_eff != dlfs_pkg::PH_HEADER && body_rem_ff == '0) begin
         phase_eff = dlfs_pkg::PH_HEADER;
      end
      if (phase_eff == dlfs_pkg::PH_META && meta_rem_ff == '0) begin
         phase_eff = dlfs_pkg::PH_FILE;
      end
   end

   // Pick the length words out of the completed header
   assign hdr_full   = {hdr_shift_ff[dlfs_pkg::HDR_BITS-9:0], in_byte};
   assign total_word = hdr_full[TOTAL_LSB +: LEN_BITS];
   assign meta_len   = hdr_full[LEN_BITS-1:0];
   assign body_len   = total_word - OVERHEAD;

   // Advance the parser for the current byte
   always_comb begin
      phase_in     = phase_eff;
      hdr_cnt_in   = hdr_cnt_ff;
      hdr_shift_in = hdr_shift_ff;
      meta_rem_in  = meta_rem_ff;
      body_rem_in  = body_rem_ff;
      res_valid    = 1'b0;
      res          = '0;
      unique case (phase_eff)
         dlfs_pkg::PH_HEADER: begin
            hdr_shift_in = hdr_full;
            hdr_cnt_in   = hdr_cnt_ff + 1'b1;
            if (hdr_cnt_ff == HDR_LAST) begin
               hdr_shift_in = '0;
               if (total_word < OVERHEAD) begin
                  res_valid         = 1'b1;
                  res.kind          = dlfs_pkg::KIND_BAD;
                  res.last_in_frame = 1'b1;
               end else if (meta_len > body_len) begin
                  body_rem_in       = body_len;
                  meta_rem_in       = '0;
                  phase_in          = (body_len != '0) ? dlfs_pkg::PH_SKIP
                                                       : dlfs_pkg::PH_HEADER;
                  res_valid         = 1'b1;
                  res.kind          = dlfs_pkg::KIND_BAD;
                  res.last_in_frame = 1'b1;
               end else if (body_len == '0) begin
                  res_valid         = 1'b1;
                  res.kind          = dlfs_pkg::KIND_EMPTY;
                  res.last_in_frame = 1'b1;
               end else begin
                  body_rem_in = body_len;
                  meta_rem_in = meta_len;
                  phase_in    = (meta_len != '0) ? dlfs_pkg::PH_META
                                                 : dlfs_pkg::PH_FILE;
               end
            end
         end
         dlfs_pkg::PH_SKIP: begin
            body_rem_in = body_rem_ff - ONE;
            if (body_rem_ff == ONE) begin
               phase_in = dlfs_pkg::PH_HEADER;
            end
         end
         dlfs_pkg::PH_META: begin
            meta_rem_in       = meta_rem_ff - ONE;
            body_rem_in       = body_rem_ff - ONE;
            res_valid         = 1'b1;
            res.out_byte      = in_byte;
            res.kind          = dlfs_pkg::KIND_META;
            res.last_in_part  = (meta_rem_ff == ONE);
            res.last_in_frame = (body_rem_ff == ONE);
            if (body_rem_ff == ONE) begin
               phase_in = dlfs_pkg::PH_HEADER;
            end else if (meta_rem_ff == ONE) begin
               phase_in = dlfs_pkg::PH_FILE;
            end
         end
         dlfs_pkg::PH_FILE: begin
            body_rem_in       = body_rem_ff - ONE;
            res_valid         = 1'b1;
            res.out_byte      = in_byte;
            res.kind          = dlfs_pkg::KIND_FILE;
            res.last_in_part  = (body_rem_ff == ONE);
            res.last_in_frame = (body_rem_ff == ONE);
            if (body_rem_ff == ONE) begin
               phase_in = dlfs_pkg::PH_HEADER;
            end
         end
         default: begin
            phase_in = dlfs_pkg::PH_HEADER;
         end
      endcase
   end

   // Hold state between transactions, update on accept
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= dlfs_pkg::PH_HEADER;
         hdr_cnt_ff   <= '0;
         hdr_shift_ff <= '0;
         meta_rem_ff  <= '0;
         body_rem_ff  <= '0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         hdr_cnt_ff   <= hdr_cnt_in;
         hdr_shift_ff <= hdr_shift_in;
         meta_rem_ff  <= meta_rem_in;
         body_rem_ff  <= body_rem_in;
      end
   end

endmodule

>>> rtl/dlfs_out_buf.sv
// Result register with a skid stage so input and output stall independently.
module dlfs_out_buf (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  dlfs_pkg::rsp_type push_data,
   output logic              full,
   output logic              out_valid,
   input  logic              out_stall,
   output dlfs_pkg::rsp_type out_data
);

   logic              main_valid_ff, skid_valid_ff;
   dlfs_pkg::rsp_type main_ff, skid_ff;
   logic              pop;

   assign pop       = main_valid_ff && !out_stall;
   assign full      = skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

   // Track occupancy of the main and skid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (main_valid_ff && !pop) begin
            skid_valid_ff <= 1'b1;
         end else begin
            main_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         main_valid_ff <= 1'b0;
      end
   end

   // Move payload: refill main from skid, else capture new transaction
   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            main_ff <= skid_ff;
         end
      end else if (push) begin
         if (main_valid_ff && !pop) begin
            skid_ff <= push_data;
         end else begin
            main_ff <= push_data;
         end
      end
   end

endmodule
